// File: hw/rtl/bjc_pkg.sv
// types, widths and arithmetic steps for the bezier joint continuity block
`default_nettype none

package bjc_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MIR_W   = COORD_W + 2;
    localparam int MAG_W   = COORD_W;
    localparam int SQ_W    = 2 * MAG_W + 1;
    localparam int FRAC_SH = 32;
    localparam int RAD_W   = SQ_W + FRAC_SH;
    localparam int RT_W    = (RAD_W + 1) / 2;
    localparam int RAD_PAD = 2 * RT_W;
    localparam int REM_W   = RT_W + 2;
    localparam int PMUL_W  = MAG_W + RT_W;
    localparam int PROD_W  = PMUL_W + 1;
    localparam int RES_W   = PROD_W + 2;

    localparam logic MODE_ALIGN  = 1'b0;
    localparam logic MODE_MIRROR = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic              valid;
        logic              mir;
        logic              deg;
        t_coord            cx;
        t_coord            cy;
        logic              sx;
        logic              sy;
        logic [MAG_W-1:0]  ax;
        logic [MAG_W-1:0]  ay;
        t_coord            mx;
        t_coord            my;
        logic              movf;
        logic [RT_W-1:0]   lmag;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [RT_W-1:0]    root;
        logic [RAD_PAD-1:0] rad;
    } t_sqs;

    typedef struct packed {
        logic [RT_W-1:0]   rem;
        logic [PROD_W-1:0] q;
        logic [PROD_W-1:0] dvd;
    } t_dvs;

    typedef struct packed {
        logic   ovf;
        t_coord val;
    } t_sat;

    // one result bit of the restoring square root
    function automatic t_sqs sq_step(input t_sqs s);
        t_sqs             o;
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] trial;
        sh    = {s.rem[REM_W-3:0], s.rad[RAD_PAD-1 -: 2]};
        trial = {s.root, 2'b01};
        o.rad = {s.rad[RAD_PAD-3:0], 2'b00};
        if (sh >= trial) begin
            o.rem  = sh - trial;
            o.root = {s.root[RT_W-2:0], 1'b1};
        end else begin
            o.rem  = sh;
            o.root = {s.root[RT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit of the restoring divider
    function automatic t_dvs dv_step(input t_dvs s, input logic [RT_W-1:0] d);
        t_dvs          o;
        logic [RT_W:0] sh;
        logic [RT_W:0] df;
        sh    = {s.rem, s.dvd[PROD_W-1]};
        df    = sh - {1'b0, d};
        o.dvd = {s.dvd[PROD_W-2:0], 1'b0};
        if (sh >= {1'b0, d}) begin
            o.rem = df[RT_W-1:0];
            o.q   = {s.q[PROD_W-2:0], 1'b1};
        end else begin
            o.rem = sh[RT_W-1:0];
            o.q   = {s.q[PROD_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_sat sat(input logic signed [RES_W-1:0] v);
        t_sat                    o;
        logic signed [RES_W-1:0] hi;
        logic signed [RES_W-1:0] lo;
        hi = {{(RES_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        lo = {{(RES_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
        if (v > hi) begin
            o.ovf = 1'b1;
            o.val = COORD_MAX;
        end else if (v < lo) begin
            o.ovf = 1'b1;
            o.val = COORD_MIN;
        end else begin
            o.ovf = 1'b0;
            o.val = v[COORD_W-1:0];
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bezier_joint_continuity_top.sv
// Corrects the outgoing handle of a cubic Bezier joint, fully pipelined.
// One transaction is taken every clock cycle and busy stays low. Each result appears
// with o_valid at the end of 6 + RT_W + PROD_W register stages, most of them in the
// square root (one root bit per stage, 33 stages) and the divider (one quotient bit
// per stage, 50 stages). Results cannot be held off; a sink must take o_valid
// whenever it is high. The mode register is sampled with each transaction.
`default_nettype none

module bezier_joint_continuity_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_joint_mode_we,
    input  wire logic            i_joint_mode,
    input  wire logic            start,
    output logic                 busy,
    input  wire bjc_pkg::t_coord i_left_x,
    input  wire bjc_pkg::t_coord i_left_y,
    input  wire bjc_pkg::t_coord i_center_x,
    input  wire bjc_pkg::t_coord i_center_y,
    input  wire bjc_pkg::t_coord i_right_x,
    input  wire bjc_pkg::t_coord i_right_y,
    output logic                 o_valid,
    output bjc_pkg::t_coord      o_new_right_x,
    output bjc_pkg::t_coord      o_new_right_y,
    output logic                 o_degenerate,
    output logic                 o_overflow
);

    logic r_mode;

    logic            r_in_v;
    logic            r_in_mode;
    bjc_pkg::t_coord r_in_lx, r_in_ly, r_in_cx, r_in_cy, r_in_rx, r_in_ry;

    bjc_pkg::t_side                     n_a_side, r_a_side;
    logic [bjc_pkg::MAG_W-1:0]          n_a_rx, n_a_ry, r_a_rx, r_a_ry;
    logic signed [bjc_pkg::DIFF_W-1:0]  dlx, dly, drx, dry;
    logic [bjc_pkg::DIFF_W-1:0]         tlx, tly, trx, try_;
    logic signed [bjc_pkg::MIR_W-1:0]   mir_x, mir_y;
    bjc_pkg::t_sat                      sat_mx, sat_my;

    bjc_pkg::t_side                     r_b_side;
    logic [bjc_pkg::SQ_W-1:0]           r_b_sl, r_b_sr;

    bjc_pkg::t_sqs                      sq_l0, sq_r0;
    bjc_pkg::t_sqs                      r_sql [bjc_pkg::RT_W];
    bjc_pkg::t_sqs                      r_sqr [bjc_pkg::RT_W];
    bjc_pkg::t_side                     r_sq_side [bjc_pkg::RT_W];

    bjc_pkg::t_side                     n_mul_side, r_mul_side;
    logic [bjc_pkg::PMUL_W-1:0]         n_px, n_py, r_px, r_py;

    bjc_pkg::t_side                     r_add_side;
    logic [bjc_pkg::PROD_W-1:0]         r_add_dx, r_add_dy;

    bjc_pkg::t_dvs                      dv_x0, dv_y0;
    bjc_pkg::t_dvs                      r_dvx [bjc_pkg::PROD_W];
    bjc_pkg::t_dvs                      r_dvy [bjc_pkg::PROD_W];
    bjc_pkg::t_side                     r_dv_side [bjc_pkg::PROD_W];

    bjc_pkg::t_side                     dv_last;
    logic signed [bjc_pkg::RES_W-1:0]   cex, cey, qex, qey, sum_x, sum_y;
    bjc_pkg::t_sat                      sat_x, sat_y;
    bjc_pkg::t_coord                    n_out_x, n_out_y;
    logic                               n_out_deg, n_out_ovf;

    logic            r_out_v;
    bjc_pkg::t_coord r_out_x, r_out_y;
    logic            r_out_deg, r_out_ovf;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bjc_pkg::MODE_ALIGN;
        end else if (i_joint_mode_we) begin
            r_mode <= i_joint_mode;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_mode <= r_mode;
        r_in_lx   <= i_left_x;
        r_in_ly   <= i_left_y;
        r_in_cx   <= i_center_x;
        r_in_cy   <= i_center_y;
        r_in_rx   <= i_right_x;
        r_in_ry   <= i_right_y;
    end

    // differences, magnitudes and the mirror result
    always_comb begin
        dlx   = bjc_pkg::DIFF_W'(r_in_cx) - bjc_pkg::DIFF_W'(r_in_lx);
        dly   = bjc_pkg::DIFF_W'(r_in_cy) - bjc_pkg::DIFF_W'(r_in_ly);
        drx   = bjc_pkg::DIFF_W'(r_in_rx) - bjc_pkg::DIFF_W'(r_in_cx);
        dry   = bjc_pkg::DIFF_W'(r_in_ry) - bjc_pkg::DIFF_W'(r_in_cy);
        tlx   = dlx[bjc_pkg::DIFF_W-1] ? -dlx : dlx;
        tly   = dly[bjc_pkg::DIFF_W-1] ? -dly : dly;
        trx   = drx[bjc_pkg::DIFF_W-1] ? -drx : drx;
        try_  = dry[bjc_pkg::DIFF_W-1] ? -dry : dry;
        mir_x = (bjc_pkg::MIR_W'(r_in_cx) <<< 1) - bjc_pkg::MIR_W'(r_in_lx);
        mir_y = (bjc_pkg::MIR_W'(r_in_cy) <<< 1) - bjc_pkg::MIR_W'(r_in_ly);
        sat_mx = bjc_pkg::sat(bjc_pkg::RES_W'(mir_x));
        sat_my = bjc_pkg::sat(bjc_pkg::RES_W'(mir_y));

        n_a_side.valid = r_in_v;
        n_a_side.mir   = (r_in_mode == bjc_pkg::MODE_MIRROR);
        n_a_side.deg   = (r_in_mode == bjc_pkg::MODE_ALIGN) && (dlx == '0) && (dly == '0);
        n_a_side.cx    = r_in_cx;
        n_a_side.cy    = r_in_cy;
        n_a_side.sx    = dlx[bjc_pkg::DIFF_W-1];
        n_a_side.sy    = dly[bjc_pkg::DIFF_W-1];
        n_a_side.ax    = tlx[bjc_pkg::MAG_W-1:0];
        n_a_side.ay    = tly[bjc_pkg::MAG_W-1:0];
        n_a_side.mx    = sat_mx.val;
        n_a_side.my    = sat_my.val;
        n_a_side.movf  = sat_mx.ovf | sat_my.ovf;
        n_a_side.lmag  = '0;
        n_a_rx         = trx[bjc_pkg::MAG_W-1:0];
        n_a_ry         = try_[bjc_pkg::MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
        end else begin
            r_a_side <= n_a_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_rx <= n_a_rx;
        r_a_ry <= n_a_ry;
    end

    // squared lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_side <= '0;
        end else begin
            r_b_side <= r_a_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_sl <= bjc_pkg::SQ_W'(r_a_side.ax) * bjc_pkg::SQ_W'(r_a_side.ax) +
                  bjc_pkg::SQ_W'(r_a_side.ay) * bjc_pkg::SQ_W'(r_a_side.ay);
        r_b_sr <= bjc_pkg::SQ_W'(r_a_rx) * bjc_pkg::SQ_W'(r_a_rx) +
                  bjc_pkg::SQ_W'(r_a_ry) * bjc_pkg::SQ_W'(r_a_ry);
    end

    // square root pipeline
    always_comb begin
        sq_l0.rem  = '0;
        sq_l0.root = '0;
        sq_l0.rad  = bjc_pkg::RAD_PAD'({r_b_sl, {bjc_pkg::FRAC_SH{1'b0}}});
        sq_r0.rem  = '0;
        sq_r0.root = '0;
        sq_r0.rad  = bjc_pkg::RAD_PAD'({r_b_sr, {bjc_pkg::FRAC_SH{1'b0}}});
    end

    for (genvar k = 0; k < bjc_pkg::RT_W; k++) begin : g_sq
        bjc_pkg::t_sqs  in_l;
        bjc_pkg::t_sqs  in_r;
        bjc_pkg::t_side in_s;
        if (k == 0) begin : g_first
            assign in_l = sq_l0;
            assign in_r = sq_r0;
            assign in_s = r_b_side;
        end else begin : g_next
            assign in_l = r_sql[k-1];
            assign in_r = r_sqr[k-1];
            assign in_s = r_sq_side[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_side[k] <= '0;
            end else begin
                r_sq_side[k] <= in_s;
            end
        end
        always_ff @(posedge i_clk) begin
            r_sql[k] <= bjc_pkg::sq_step(in_l);
            r_sqr[k] <= bjc_pkg::sq_step(in_r);
        end
    end

    // scale by the outgoing length
    always_comb begin
        n_mul_side      = r_sq_side[bjc_pkg::RT_W-1];
        n_mul_side.lmag = r_sql[bjc_pkg::RT_W-1].root;
        n_px            = r_sq_side[bjc_pkg::RT_W-1].ax * r_sqr[bjc_pkg::RT_W-1].root;
        n_py            = r_sq_side[bjc_pkg::RT_W-1].ay * r_sqr[bjc_pkg::RT_W-1].root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_side <= '0;
            r_add_side <= '0;
        end else begin
            r_mul_side <= n_mul_side;
            r_add_side <= r_mul_side;
        end
    end

    // rounding term for the divide
    always_ff @(posedge i_clk) begin
        r_px     <= n_px;
        r_py     <= n_py;
        r_add_dx <= bjc_pkg::PROD_W'(r_px) + bjc_pkg::PROD_W'(r_mul_side.lmag >> 1);
        r_add_dy <= bjc_pkg::PROD_W'(r_py) + bjc_pkg::PROD_W'(r_mul_side.lmag >> 1);
    end

    // divider pipeline
    always_comb begin
        dv_x0.rem = '0;
        dv_x0.q   = '0;
        dv_x0.dvd = r_add_dx;
        dv_y0.rem = '0;
        dv_y0.q   = '0;
        dv_y0.dvd = r_add_dy;
    end

    for (genvar k = 0; k < bjc_pkg::PROD_W; k++) begin : g_dv
        bjc_pkg::t_dvs  in_x;
        bjc_pkg::t_dvs  in_y;
        bjc_pkg::t_side in_s;
        if (k == 0) begin : g_first
            assign in_x = dv_x0;
            assign in_y = dv_y0;
            assign in_s = r_add_side;
        end else begin : g_next
            assign in_x = r_dvx[k-1];
            assign in_y = r_dvy[k-1];
            assign in_s = r_dv_side[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_side[k] <= '0;
            end else begin
                r_dv_side[k] <= in_s;
            end
        end
        always_ff @(posedge i_clk) begin
            r_dvx[k] <= bjc_pkg::dv_step(in_x, in_s.lmag);
            r_dvy[k] <= bjc_pkg::dv_step(in_y, in_s.lmag);
        end
    end

    // offset from the joint, saturation and mode select
    always_comb begin
        dv_last = r_dv_side[bjc_pkg::PROD_W-1];
        cex     = bjc_pkg::RES_W'(dv_last.cx);
        cey     = bjc_pkg::RES_W'(dv_last.cy);
        qex     = {2'b00, r_dvx[bjc_pkg::PROD_W-1].q};
        qey     = {2'b00, r_dvy[bjc_pkg::PROD_W-1].q};
        sum_x   = dv_last.sx ? cex - qex : cex + qex;
        sum_y   = dv_last.sy ? cey - qey : cey + qey;
        sat_x   = bjc_pkg::sat(sum_x);
        sat_y   = bjc_pkg::sat(sum_y);
        priority if (dv_last.mir) begin
            n_out_x   = dv_last.mx;
            n_out_y   = dv_last.my;
            n_out_deg = 1'b0;
            n_out_ovf = dv_last.movf;
        end else if (dv_last.deg) begin
            n_out_x   = dv_last.cx;
            n_out_y   = dv_last.cy;
            n_out_deg = 1'b1;
            n_out_ovf = 1'b0;
        end else begin
            n_out_x   = sat_x.val;
            n_out_y   = sat_y.val;
            n_out_deg = 1'b0;
            n_out_ovf = sat_x.ovf | sat_y.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= dv_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
        r_out_deg <= n_out_deg;
        r_out_ovf <= n_out_ovf;
    end

    assign o_valid       = r_out_v;
    assign o_new_right_x = r_out_x;
    assign o_new_right_y = r_out_y;
    assign o_degenerate  = r_out_deg;
    assign o_overflow    = r_out_ovf;

    a_deg_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> !o_overflow)
        else $error("degenerate transaction flagged overflow");

    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |->
            (o_new_right_x == bjc_pkg::COORD_MAX) || (o_new_right_x == bjc_pkg::COORD_MIN) ||
            (o_new_right_y == bjc_pkg::COORD_MAX) || (o_new_right_y == bjc_pkg::COORD_MIN))
        else $error("overflow without a saturated coordinate");

    a_deg_sqrt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_side.valid && r_mul_side.deg |-> r_mul_side.lmag == '0)
        else $error("zero incoming handle with nonzero length");

endmodule

`default_nettype wire
